// ----- design/lost_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lost_pkg
// Shared sizes, request and status codes, payload structs and the command and
// status bundles between the occupancy tracker controller and datapath.
// ----------------------------------------------------------------------------
package lost_pkg;

  // Lattice sizing
  localparam int MAX_SITES   = 4096;
  localparam int SITE_W      = $clog2(MAX_SITES);
  localparam int COUNT_W     = SITE_W + 1;
  localparam int TYPE_BITS   = 4;
  localparam int ORIENT_BITS = 4;
  localparam int SITE_DATA_W = TYPE_BITS + ORIENT_BITS;

  // Request codes
  localparam logic [1:0] REQ_LOAD       = 2'd0;
  localparam logic [1:0] REQ_SWAP       = 2'd1;
  localparam logic [1:0] REQ_PICK_FULL  = 2'd2;
  localparam logic [1:0] REQ_PICK_EMPTY = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_SITE = 2'd1;
  localparam logic [1:0] STAT_BAD_SLOT = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]             req_type;
    logic [SITE_W-1:0]      site_a;
    logic [SITE_W-1:0]      site_b;
    logic [TYPE_BITS-1:0]   site_type;
    logic [ORIENT_BITS-1:0] site_orientation;
    logic [SITE_W-1:0]      draw_slot;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [SITE_W-1:0]  picked_site;
    logic [COUNT_W-1:0] full_count;
  } rsp_t;

  // Contents of one lattice site
  typedef struct packed {
    logic [TYPE_BITS-1:0]   kind;
    logic [ORIENT_BITS-1:0] orient;
  } site_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted request
    logic check;        // evaluate the request and latch its status
    logic load_commit;  // write a loaded site and append it to its list
    logic rd_b;         // read address is site b instead of site a
    logic lat_a;        // latch site a contents and slot
    logic swap_wr_a;    // write site a, latch site b contents and slot
    logic swap_wr_b;    // write site b, first map update, both list updates
    logic swap_wr_c;    // second map update
    logic pick_cap;     // latch the picked site
    logic result_load;  // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] req_type;
    logic       req_ok;
    logic       out_free;
  } dp_sts_t;

endpackage

// ----- design/lost_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lost_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lost_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lost_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lost_ctrl
// Request sequencer: steps each accepted transaction through check, RAM
// reads and writes, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lost_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lost_pkg::dp_sts_t sts,
  output lost_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    PICK_CAP,
    SW_RD_B,
    SW_WR_A,
    SW_WR_B,
    SW_WR_C,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = CHECK;
        end
      end
      CHECK: begin
        cmd.check       = 1'b1;
        cmd.load_commit = (sts.req_type == lost_pkg::REQ_LOAD) && sts.req_ok;
        if (sts.req_type inside {lost_pkg::REQ_PICK_FULL, lost_pkg::REQ_PICK_EMPTY}) begin
          state_next = PICK_CAP;
        end else if ((sts.req_type == lost_pkg::REQ_SWAP) && sts.req_ok) begin
          state_next = SW_RD_B;
        end else begin
          state_next = FINISH;
        end
      end
      PICK_CAP: begin
        cmd.pick_cap = 1'b1;
        state_next   = FINISH;
      end
      SW_RD_B: begin
        cmd.rd_b   = 1'b1;
        cmd.lat_a  = 1'b1;
        state_next = SW_WR_A;
      end
      SW_WR_A: begin
        cmd.swap_wr_a = 1'b1;
        state_next    = SW_WR_B;
      end
      SW_WR_B: begin
        cmd.swap_wr_b = 1'b1;
        state_next    = SW_WR_C;
      end
      SW_WR_C: begin
        cmd.swap_wr_c = 1'b1;
        state_next    = FINISH;
      end
      FINISH: begin
        cmd.result_load = sts.out_free;
        if (sts.out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != IDLE);

endmodule

// ----- design/lost_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lost_dp
// Datapath: site, list and slot map RAMs, occupancy counters, request
// checks and the result register.
// ----------------------------------------------------------------------------
module lost_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lost_pkg::req_t                 req,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lost_pkg::COUNT_W-1:0]   cfg_data,
  input  lost_pkg::dp_cmd_t              cmd,
  output lost_pkg::dp_sts_t              sts,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output lost_pkg::rsp_t                 rsp
);

  localparam int SW = lost_pkg::SITE_W;
  localparam int CW = lost_pkg::COUNT_W;

  // Registers
  lost_pkg::req_t  q;
  logic [CW-1:0]   active_sites;
  logic [CW-1:0]   full_total;
  logic [CW-1:0]   empty_total;
  logic [1:0]      stat;
  logic [SW-1:0]   picked;
  lost_pkg::site_t da_site;
  lost_pkg::site_t db_site;
  logic [SW-1:0]   ma_slot;
  logic [SW-1:0]   mb_slot;

  // Combinational
  logic [CW:0]     occ_sum;
  logic [CW-1:0]   loaded;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   a_ext;
  logic [CW-1:0]   b_ext;
  logic [CW-1:0]   slot_ext;
  logic            load_ok;
  logic            swap_ok;
  logic            pick_ok;
  logic            req_ok;
  logic            a_empty;
  logic            b_empty;
  logic            differ;
  logic            new_full;
  logic [SW-1:0]   was_full;
  logic [SW-1:0]   was_empty;
  logic [SW-1:0]   fslot;
  logic [SW-1:0]   eslot;

  // RAM ports
  logic            site_we;
  logic [SW-1:0]   site_waddr;
  lost_pkg::site_t site_wdata;
  lost_pkg::site_t site_rdata;
  logic [SW-1:0]   rd_addr;
  logic            full_we;
  logic [SW-1:0]   full_waddr;
  logic [SW-1:0]   full_wdata;
  logic [SW-1:0]   full_rdata;
  logic            empty_we;
  logic [SW-1:0]   empty_waddr;
  logic [SW-1:0]   empty_wdata;
  logic [SW-1:0]   empty_rdata;
  logic            map_we;
  logic [SW-1:0]   map_waddr;
  logic [SW-1:0]   map_wdata;
  logic [SW-1:0]   map_rdata;

  // Request checks
  assign occ_sum  = {1'b0, full_total} + {1'b0, empty_total};
  assign loaded   = occ_sum[CW-1:0];
  assign lim      = (active_sites > CW'(lost_pkg::MAX_SITES)) ?
                    CW'(lost_pkg::MAX_SITES) : active_sites;
  assign a_ext    = CW'(q.site_a);
  assign b_ext    = CW'(q.site_b);
  assign slot_ext = CW'(q.draw_slot);
  assign load_ok  = (a_ext == loaded) && (loaded < lim);
  assign swap_ok  = (a_ext < loaded) && (b_ext < loaded) && (a_ext < lim) && (b_ext < lim);
  assign pick_ok  = (q.req_type == lost_pkg::REQ_PICK_FULL) ? (slot_ext < full_total) :
                                                               (slot_ext < empty_total);

  always_comb begin
    case (q.req_type)
      lost_pkg::REQ_LOAD: req_ok = load_ok;
      lost_pkg::REQ_SWAP: req_ok = swap_ok;
      default:            req_ok = pick_ok;
    endcase
  end
  assign sts.req_ok   = req_ok;
  assign sts.req_type = q.req_type;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  // Swap bookkeeping: each site takes over the slot the other one held
  assign a_empty   = (da_site.orient == '0);
  assign b_empty   = (db_site.orient == '0);
  assign differ    = (a_empty != b_empty);
  assign was_full  = a_empty ? q.site_b : q.site_a;
  assign was_empty = a_empty ? q.site_a : q.site_b;
  assign fslot     = a_empty ? mb_slot : ma_slot;
  assign eslot     = a_empty ? ma_slot : mb_slot;
  assign new_full  = (q.site_orientation != '0);

  // Read addresses
  assign rd_addr = cmd.rd_b ? q.site_b : q.site_a;

  // Site store writes
  always_comb begin
    site_we    = cmd.load_commit || cmd.swap_wr_a || cmd.swap_wr_b;
    site_waddr = q.site_a;
    site_wdata = '{kind: q.site_type, orient: q.site_orientation};
    if (cmd.swap_wr_a) begin
      site_wdata = site_rdata;
    end else if (cmd.swap_wr_b) begin
      site_waddr = q.site_b;
      site_wdata = da_site;
    end
  end

  // List writes
  always_comb begin
    full_we     = (cmd.load_commit && new_full) || (cmd.swap_wr_b && differ);
    full_waddr  = cmd.swap_wr_b ? fslot : full_total[SW-1:0];
    full_wdata  = cmd.swap_wr_b ? was_empty : q.site_a;
    empty_we    = (cmd.load_commit && !new_full) || (cmd.swap_wr_b && differ);
    empty_waddr = cmd.swap_wr_b ? eslot : empty_total[SW-1:0];
    empty_wdata = cmd.swap_wr_b ? was_full : q.site_a;
  end

  // Slot map writes
  always_comb begin
    map_we    = cmd.load_commit || ((cmd.swap_wr_b || cmd.swap_wr_c) && differ);
    map_waddr = cmd.swap_wr_c ? q.site_b : q.site_a;
    if (cmd.swap_wr_b) begin
      map_wdata = mb_slot;
    end else if (cmd.swap_wr_c) begin
      map_wdata = ma_slot;
    end else begin
      map_wdata = new_full ? full_total[SW-1:0] : empty_total[SW-1:0];
    end
  end

  lost_ram #(.WIDTH(lost_pkg::SITE_DATA_W), .DEPTH(lost_pkg::MAX_SITES)) u_site_ram (
    .clk   (clk),
    .we    (site_we),
    .waddr (site_waddr),
    .wdata (site_wdata),
    .raddr (rd_addr),
    .rdata (site_rdata)
  );

  lost_ram #(.WIDTH(SW), .DEPTH(lost_pkg::MAX_SITES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (rd_addr),
    .rdata (map_rdata)
  );

  lost_ram #(.WIDTH(SW), .DEPTH(lost_pkg::MAX_SITES)) u_full_ram (
    .clk   (clk),
    .we    (full_we),
    .waddr (full_waddr),
    .wdata (full_wdata),
    .raddr (q.draw_slot),
    .rdata (full_rdata)
  );

  lost_ram #(.WIDTH(SW), .DEPTH(lost_pkg::MAX_SITES)) u_empty_ram (
    .clk   (clk),
    .we    (empty_we),
    .waddr (empty_waddr),
    .wdata (empty_wdata),
    .raddr (q.draw_slot),
    .rdata (empty_rdata)
  );

  // Capture request, status, picked site and swap operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q <= req;
    end
    if (cmd.check) begin
      picked <= '0;
      if (sts.req_ok) begin
        stat <= lost_pkg::STAT_OK;
      end else if (q.req_type inside {lost_pkg::REQ_PICK_FULL, lost_pkg::REQ_PICK_EMPTY}) begin
        stat <= lost_pkg::STAT_BAD_SLOT;
      end else begin
        stat <= lost_pkg::STAT_BAD_SITE;
      end
    end
    if (cmd.pick_cap && sts.req_ok) begin
      picked <= (q.req_type == lost_pkg::REQ_PICK_FULL) ? full_rdata : empty_rdata;
    end
    if (cmd.lat_a) begin
      da_site <= site_rdata;
      ma_slot <= map_rdata;
    end
    if (cmd.swap_wr_a) begin
      db_site <= site_rdata;
      mb_slot <= map_rdata;
    end
    if (cmd.result_load) begin
      rsp.status      <= stat;
      rsp.picked_site <= picked;
      rsp.full_count  <= full_total;
    end
  end

  // Configuration, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active_sites <= CW'(lost_pkg::MAX_SITES);
      full_total   <= '0;
      empty_total  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_sites <= cfg_data;
      end
      if (cmd.load_commit) begin
        if (new_full) begin
          full_total <= full_total + 1'b1;
        end else begin
          empty_total <= empty_total + 1'b1;
        end
      end
      if (cmd.result_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Occupancy never exceeds the lattice
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ_sum <= (CW + 1)'(lost_pkg::MAX_SITES))
    else $error("occupancy count beyond lattice size");

  // A committed load grows occupancy by exactly one
  a_load_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.load_commit |=> occ_sum == $past(occ_sum) + 1'b1)
    else $error("load commit did not advance occupancy by one");

  // Only a load moves the counters; swaps keep the list lengths
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.load_commit |=> $stable(full_total) && $stable(empty_total))
    else $error("list length changed without a load");

endmodule

// ----- design/lattice_occupancy_swap_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_occupancy_swap_tracker
// Lattice site store with full and empty site lists and a site to slot map.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; the next is accepted while the
// previous result still waits in the output register. After the check, a
// load or invalid swap goes to the result; a pick first latches the picked
// site; a valid swap does its RAM accesses, paced by the single read and
// single write port of the site and slot map RAMs, which need two reads and
// up to two writes per swapped pair. All stores power up undefined and are
// only read where a load has written them, so there is no clearing pass
// after reset. Configuration writes are always taken (cfg_ready is high)
// and must be issued only while no transaction is in work.
module lattice_occupancy_swap_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  lost_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output lost_pkg::rsp_t               rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lost_pkg::COUNT_W-1:0] cfg_data
);

  lost_pkg::dp_cmd_t cmd;
  lost_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer
  lost_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stores, counters and result register
  lost_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- bench/lattice_occupancy_swap_tracker_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_occupancy_swap_tracker_checker
// Watches the request, result and register channels of the occupancy tracker.
// It keeps its own copy of the lattice, the full and empty site lists and the
// slot map, forms the expected result of every accepted request and compares
// each accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module lattice_occupancy_swap_tracker_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_stall,
  input  lost_pkg::req_t               req,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  lost_pkg::rsp_t               rsp,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [lost_pkg::COUNT_W-1:0] cfg_data,
  output int                           mismatches,
  output int                           owed_results,
  output int                           results_seen,
  output logic [lost_pkg::COUNT_W-1:0] full_sites,
  output logic [lost_pkg::COUNT_W-1:0] empty_sites
);

  localparam int SW = lost_pkg::SITE_W;
  localparam int CW = lost_pkg::COUNT_W;

  // Tracked lattice and bookkeeping
  logic [CW-1:0]                    active_sites;
  logic [lost_pkg::TYPE_BITS-1:0]   kind_mem   [lost_pkg::MAX_SITES];
  logic [lost_pkg::ORIENT_BITS-1:0] orient_mem [lost_pkg::MAX_SITES];
  logic [SW-1:0]                    full_list  [lost_pkg::MAX_SITES];
  logic [SW-1:0]                    empty_list [lost_pkg::MAX_SITES];
  logic [SW-1:0]                    slot_map   [lost_pkg::MAX_SITES];
  int unsigned                      full_total;
  int unsigned                      empty_total;

  lost_pkg::rsp_t owed_q [$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Apply one request to the tracked lattice and return the result it owes
  function automatic lost_pkg::rsp_t track_request(input lost_pkg::req_t r);
    lost_pkg::rsp_t                   res;
    int unsigned                      loaded;
    int unsigned                      lim;
    int unsigned                      a;
    int unsigned                      b;
    int unsigned                      slot;
    int unsigned                      was_full;
    int unsigned                      was_empty;
    int unsigned                      eslot;
    int unsigned                      fslot;
    logic                             a_empty;
    logic                             b_empty;
    logic [lost_pkg::TYPE_BITS-1:0]   tmp_kind;
    logic [lost_pkg::ORIENT_BITS-1:0] tmp_orient;
    res = '0;
    res.status = lost_pkg::STAT_OK;
    loaded = full_total + empty_total;
    lim = (active_sites > lost_pkg::MAX_SITES) ? lost_pkg::MAX_SITES : active_sites;
    a = r.site_a;
    b = r.site_b;
    slot = r.draw_slot;
    case (r.req_type)
      lost_pkg::REQ_LOAD: begin
        if (a != loaded || loaded >= lim) begin
          res.status = lost_pkg::STAT_BAD_SITE;
        end else begin
          kind_mem[a] = r.site_type;
          orient_mem[a] = r.site_orientation;
          if (r.site_orientation == '0) begin
            empty_list[empty_total] = SW'(a);
            slot_map[a] = SW'(empty_total);
            empty_total++;
          end else begin
            full_list[full_total] = SW'(a);
            slot_map[a] = SW'(full_total);
            full_total++;
          end
        end
      end
      lost_pkg::REQ_SWAP: begin
        if (a >= loaded || b >= loaded || a >= lim || b >= lim) begin
          res.status = lost_pkg::STAT_BAD_SITE;
        end else begin
          a_empty = (orient_mem[a] == '0);
          b_empty = (orient_mem[b] == '0);
          tmp_kind = kind_mem[a];
          kind_mem[a] = kind_mem[b];
          kind_mem[b] = tmp_kind;
          tmp_orient = orient_mem[a];
          orient_mem[a] = orient_mem[b];
          orient_mem[b] = tmp_orient;
          // Move each site into the other's list slot when occupancy differs
          if (a_empty != b_empty) begin
            was_full = a_empty ? b : a;
            was_empty = a_empty ? a : b;
            eslot = slot_map[was_empty];
            fslot = slot_map[was_full];
            empty_list[eslot] = SW'(was_full);
            full_list[fslot] = SW'(was_empty);
            slot_map[was_empty] = SW'(fslot);
            slot_map[was_full] = SW'(eslot);
          end
        end
      end
      lost_pkg::REQ_PICK_FULL: begin
        if (slot >= full_total) res.status = lost_pkg::STAT_BAD_SLOT;
        else res.picked_site = full_list[slot];
      end
      lost_pkg::REQ_PICK_EMPTY: begin
        if (slot >= empty_total) res.status = lost_pkg::STAT_BAD_SLOT;
        else res.picked_site = empty_list[slot];
      end
      default: ;
    endcase
    res.full_count = CW'(full_total);
    return res;
  endfunction

  assign full_sites = CW'(full_total);
  assign empty_sites = CW'(empty_total);

  // Track requests and register writes, check each result transaction
  always @(posedge clk) begin
    lost_pkg::rsp_t want;
    if (rst) begin
      active_sites = CW'(lost_pkg::MAX_SITES);
      full_total = 0;
      empty_total = 0;
      owed_q.delete();
      owed_results = 0;
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) active_sites = cfg_data;
      if (req_valid && !req_stall) owed_q.insert(owed_q.size(), track_request(req));
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (owed_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed (status %0d site %0d count %0d)",
                                  rsp.status, rsp.picked_site, rsp.full_count));
        end else begin
          want = owed_q.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", rsp.status, want.status));
          if (rsp.picked_site !== want.picked_site)
            flag_mismatch($sformatf("picked_site %0d, wanted %0d",
                                    rsp.picked_site, want.picked_site));
          if (rsp.full_count !== want.full_count)
            flag_mismatch($sformatf("full_count %0d, wanted %0d",
                                    rsp.full_count, want.full_count));
        end
      end
      owed_results = owed_q.size();
    end
  end

endmodule

// ----- bench/lattice_occupancy_swap_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_occupancy_swap_tracker_tb
// Drives load, swap and pick requests into the occupancy tracker through
// several active-site settings, with random gaps on the request side and
// random stalls on the result side. A checker beside the block predicts and
// compares every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module lattice_occupancy_swap_tracker_tb;

  localparam int PHASE_ITEMS = 220;
  localparam int SW          = lost_pkg::SITE_W;
  localparam int CW          = lost_pkg::COUNT_W;
  localparam int TW          = lost_pkg::TYPE_BITS;
  localparam int OW          = lost_pkg::ORIENT_BITS;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  lost_pkg::req_t     req;
  logic               rsp_valid;
  logic               rsp_stall;
  lost_pkg::rsp_t     rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CW-1:0]      cfg_data;

  int                 mismatches;
  int                 owed_results;
  int                 results_seen;
  logic [CW-1:0]      full_sites;
  logic [CW-1:0]      empty_sites;

  int                 cur_limit;
  int                 requests_sent;
  int                 settings_used;
  int                 leftover;
  logic               steady_tx;
  logic               steady_rx;
  int                 stall_left;
  int                 roll;

  lattice_occupancy_swap_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lattice_occupancy_swap_tracker_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .owed_results (owed_results),
    .results_seen (results_seen),
    .full_sites   (full_sites),
    .empty_sites  (empty_sites)
  );

  always #5 clk = ~clk;

  // Stall the result side in random stretches, mostly short
  always @(negedge clk) begin
    if (rst || steady_rx) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        stall_left = $urandom_range(1, 8);
        rsp_stall <= 1'b0;
      end else if (roll < 93) begin
        stall_left = $urandom_range(1, 3);
        rsp_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        rsp_stall <= 1'b1;
      end
    end
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady_tx || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a falling edge; returns at a falling edge after the handshake
  task automatic send_request(input lost_pkg::req_t r);
    int gap;
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    requests_sent++;
    gap = gap_cycles();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
  endtask

  // Hold the sender until every owed result has come back
  task automatic drain();
    int waited;
    waited = 0;
    req_valid <= 1'b0;
    while (owed_results != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= CW'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_limit = value;
    settings_used++;
    @(negedge clk);
  endtask

  function automatic lost_pkg::req_t mk(input logic [1:0] kind, input int a, input int b,
                                        input int ty, input int ori, input int slot);
    lost_pkg::req_t r;
    r.req_type = kind;
    r.site_a = SW'(a);
    r.site_b = SW'(b);
    r.site_type = TW'(ty);
    r.site_orientation = OW'(ori);
    r.draw_slot = SW'(slot);
    return r;
  endfunction

  // Draw a slot: mostly inside the list, sometimes just past it or anywhere
  function automatic int draw_for(input int len);
    int r;
    r = $urandom_range(0, 99);
    if (len > 0 && r < 80) return $urandom_range(0, len - 1);
    if (r < 92) return len;
    return $urandom_range(0, lost_pkg::MAX_SITES - 1);
  endfunction

  // Mostly well-formed requests against the current lattice, some noise
  function automatic lost_pkg::req_t next_request();
    lost_pkg::req_t r;
    int             loaded;
    int             lim;
    int             usable;
    int             pick;
    r.req_type = 2'($urandom_range(0, 3));
    r.site_a = SW'($urandom_range(0, lost_pkg::MAX_SITES - 1));
    r.site_b = SW'($urandom_range(0, lost_pkg::MAX_SITES - 1));
    r.site_type = TW'($urandom_range(0, 15));
    r.site_orientation = OW'($urandom_range(0, 15));
    r.draw_slot = SW'($urandom_range(0, lost_pkg::MAX_SITES - 1));
    loaded = full_sites + empty_sites;
    lim = (cur_limit > lost_pkg::MAX_SITES) ? lost_pkg::MAX_SITES : cur_limit;
    usable = (loaded < lim) ? loaded : lim;
    pick = $urandom_range(0, 99);
    if (pick < 6) return r;
    if (pick < 12) begin
      r.req_type = lost_pkg::REQ_LOAD;
      if (loaded == 0 || $urandom_range(0, 1)) begin
        r.site_a = SW'(loaded + int'($urandom_range(1, 3)));
      end else begin
        r.site_a = SW'(loaded - 1);
      end
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.req_type = lost_pkg::REQ_LOAD;
      r.site_a = SW'(loaded);
      if ($urandom_range(0, 2) == 0) r.site_orientation = '0;
    end else if (pick < 65) begin
      r.req_type = lost_pkg::REQ_SWAP;
      if (usable > 0) begin
        r.site_a = SW'($urandom_range(0, usable - 1));
        if ($urandom_range(0, 9) == 0) r.site_b = r.site_a;
        else r.site_b = SW'($urandom_range(0, usable - 1));
      end
    end else if (pick < 82) begin
      r.req_type = lost_pkg::REQ_PICK_FULL;
      r.draw_slot = SW'(draw_for(full_sites));
    end else begin
      r.req_type = lost_pkg::REQ_PICK_EMPTY;
      r.draw_slot = SW'(draw_for(empty_sites));
    end
    return r;
  endfunction

  initial begin
    int limits [4];
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_limit = lost_pkg::MAX_SITES;
    requests_sent = 0;
    settings_used = 0;
    steady_tx = 1'b0;
    steady_rx = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // No sites allowed: every load and swap is rejected, picks find nothing
    write_limit(0);
    send_request(mk(lost_pkg::REQ_LOAD, 0, 0, 1, 5, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 0, 0, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_PICK_FULL, 0, 0, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_PICK_EMPTY, 0, 0, 0, 0, 4095));

    // One site: fill it, then the next load hits the limit
    write_limit(1);
    send_request(mk(lost_pkg::REQ_LOAD, 0, 0, 15, 15, 0));
    send_request(mk(lost_pkg::REQ_LOAD, 1, 0, 2, 3, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 0, 0, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_PICK_FULL, 0, 0, 0, 0, 0));

    // Above the maximum acts as the maximum; walk through the swap cases
    write_limit(8191);
    send_request(mk(lost_pkg::REQ_LOAD, 1, 0, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_LOAD, 2, 0, 9, 1, 0));
    send_request(mk(lost_pkg::REQ_LOAD, 4095, 0, 3, 2, 0));
    send_request(mk(lost_pkg::REQ_LOAD, 3, 0, 6, 0, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 0, 1, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 2, 1, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 0, 3, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 3, 2, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 1, 4095, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_SWAP, 4, 0, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_PICK_FULL, 0, 0, 0, 0, 0));
    send_request(mk(lost_pkg::REQ_PICK_FULL, 0, 0, 0, 0, 1));
    send_request(mk(lost_pkg::REQ_PICK_FULL, 0, 0, 0, 0, 2));
    send_request(mk(lost_pkg::REQ_PICK_EMPTY, 0, 0, 0, 0, 1));
    send_request(mk(lost_pkg::REQ_PICK_EMPTY, 0, 0, 0, 0, 4095));

    // Random phases: full range, a limit just ahead, above range, at or below loaded
    limits[0] = lost_pkg::MAX_SITES;
    limits[1] = -1;
    limits[2] = 8191;
    limits[3] = -2;
    foreach (limits[p]) begin
      if (limits[p] == -1) write_limit(full_sites + empty_sites + $urandom_range(15, 40));
      else if (limits[p] == -2) write_limit($urandom_range(1, full_sites + empty_sites));
      else write_limit(limits[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 30 == 0) begin
          steady_tx = ($urandom_range(0, 3) == 0);
          steady_rx = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 149) == 0) drain();
        send_request(next_request());
      end
    end

    // Let the last results come back, then give the verdict
    steady_rx = 1'b0;
    drain();
    leftover = owed_results;
    if (leftover != 0) $display("[%0t] %0d owed results never arrived", $time, leftover);
    $display("Covered %0d requests and %0d results over %0d active-site settings;",
             requests_sent, results_seen, settings_used);
    $display("lattice ended with %0d full and %0d empty sites loaded.",
             full_sites, empty_sites);
    if (mismatches == 0 && leftover == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- lattice_occupancy_swap_tracker.f -----
design/lost_pkg.sv
design/lost_ram.sv
design/lost_ctrl.sv
design/lost_dp.sv
design/lattice_occupancy_swap_tracker.sv
bench/lattice_occupancy_swap_tracker_checker.sv
bench/lattice_occupancy_swap_tracker_tb.sv
